[src/tea16_pkg.sv]
// Shared types, constants and round function for the TEA cipher core.
`default_nettype none

package tea16_pkg;

   // Number of full cipher rounds; each round occupies two cells.
   localparam int unsigned ROUNDS = 16;
   localparam int unsigned CELLS  = 2 * ROUNDS;

   localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;

   // Configuration register indexes.
   localparam logic [1:0] CSR_KEY_WORD_0 = 2'd0;
   localparam logic [1:0] CSR_KEY_WORD_1 = 2'd1;
   localparam logic [1:0] CSR_KEY_WORD_2 = 2'd2;
   localparam logic [1:0] CSR_KEY_WORD_3 = 2'd3;

   // Operation codes.
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [31:0] block_left;
      logic [31:0] block_right;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] out_left;
      logic [31:0] out_right;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] word_0;
      logic [31:0] word_1;
      logic [31:0] word_2;
      logic [31:0] word_3;
   } key_type;

   // Block in flight between cells.
   typedef struct packed {
      logic        decrypt;
      logic [31:0] left;
      logic [31:0] right;
   } stage_type;

   // Running sum for a round count, wrapped to 32 bits.
   function automatic logic [31:0] round_sum(input int unsigned k);
      logic [63:0] prod;
      prod = 64'(k) * 64'(TEA_DELTA);
      return prod[31:0];
   endfunction

   function automatic logic [31:0] mix_word(input logic [31:0] x,
                                            input logic [31:0] sum,
                                            input logic [31:0] ka,
                                            input logic [31:0] kb);
      return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
   endfunction

endpackage

`default_nettype wire

[src/tea_block_cipher_16_round_core.sv]
// Top level of the pipelined TEA encipher/decipher core.
// Usage:
//   Load the 128-bit key through the csr_ port: raise csr_wr_en with
//   csr_index selecting key word 0..3 and csr_wr_data holding the word.
//   Write keys only while no transaction is in flight.
//   Present a block on req_data with req_valid; req_data.req_type selects
//   encrypt (0) or decrypt (1). A transaction is taken on any edge with
//   req_valid and req_ready high; the result leaves on rsp_data with
//   rsp_valid and is taken on any edge with rsp_valid and rsp_ready high.
// Structure and throughput:
//   A row of 2*ROUNDS cells (32 for 16 rounds), each doing half a round.
//   One transaction enters and one leaves per cycle while rsp_ready is high.
// Stall:
//   When rsp_ready is low the last cell holds its result; earlier cells
//   keep advancing into empty slots, so req_ready drops only once every
//   cell is occupied.
// Reset:
//   Synchronous, active high; empties all cells and clears the key to 0.
`default_nettype none

module tea_block_cipher_16_round_core import tea16_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_wr_en,
   input  logic [1:0]      csr_index,
   input  logic [31:0]     csr_wr_data
);

   key_type   key_ff;
   key_type   key_in;

   // Links between cells: entry i feeds cell i, entry CELLS is the output.
   logic      link_valid [CELLS+1];
   logic      link_ready [CELLS+1];
   stage_type link_data  [CELLS+1];

   // Key registers; write only while idle.
   always_comb begin
      key_in = key_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KEY_WORD_0: key_in.word_0 = csr_wr_data;
            CSR_KEY_WORD_1: key_in.word_1 = csr_wr_data;
            CSR_KEY_WORD_2: key_in.word_2 = csr_wr_data;
            CSR_KEY_WORD_3: key_in.word_3 = csr_wr_data;
            default:        key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // Map the request onto the first link.
   assign link_valid[0]        = req_valid;
   assign req_ready            = link_ready[0];
   assign link_data[0].decrypt = req_data.req_type;
   assign link_data[0].left    = req_data.block_left;
   assign link_data[0].right   = req_data.block_right;

   // Cell i works on round i/2; both halves of a round share its sum.
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      localparam logic [31:0] SUM_ENC = round_sum(i / 2 + 1);
      localparam logic [31:0] SUM_DEC = round_sum(ROUNDS - i / 2);
      localparam logic        HALF    = (i % 2) == 1;

      tea16_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (link_valid[i]),
         .in_ready    (link_ready[i]),
         .in_data     (link_data[i]),
         .second_half (HALF),
         .sum_enc     (SUM_ENC),
         .sum_dec     (SUM_DEC),
         .key         (key_ff),
         .out_valid   (link_valid[i+1]),
         .out_ready   (link_ready[i+1]),
         .out_data    (link_data[i+1])
      );
   end

   // The last cell doubles as the output register.
   assign rsp_valid          = link_valid[CELLS];
   assign link_ready[CELLS]  = rsp_ready;
   assign rsp_data.out_left  = link_data[CELLS].left;
   assign rsp_data.out_right = link_data[CELLS].right;

endmodule

`default_nettype wire

[src/tea16_cell.sv]
// One half-round cell of the TEA pipeline: updates one half of the block.
`default_nettype none

module tea16_cell import tea16_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  stage_type   in_data,
   input  logic        second_half,
   input  logic [31:0] sum_enc,
   input  logic [31:0] sum_dec,
   input  key_type     key,
   output logic        out_valid,
   input  logic        out_ready,
   output stage_type   out_data
);

   logic        valid_ff;
   logic        valid_in;
   stage_type   data_ff;
   stage_type   data_in;
   logic        upd_left;
   logic [31:0] src;
   logic [31:0] tgt;
   logic [31:0] ka;
   logic [31:0] kb;
   logic [31:0] sum;
   logic [31:0] mix;
   logic [31:0] result;

   // Encrypt updates left then right; decrypt updates right then left.
   assign upd_left = ~(in_data.decrypt ^ second_half);
   assign src      = upd_left ? in_data.right : in_data.left;
   assign tgt      = upd_left ? in_data.left  : in_data.right;
   assign ka       = upd_left ? key.word_0    : key.word_2;
   assign kb       = upd_left ? key.word_1    : key.word_3;
   assign sum      = (in_data.decrypt == OP_DECRYPT) ? sum_dec : sum_enc;
   assign mix      = mix_word(src, sum, ka, kb);
   assign result   = (in_data.decrypt == OP_DECRYPT) ? (tgt - mix) : (tgt + mix);

   always_comb begin
      data_in         = in_data;
      if (upd_left) begin
         data_in.left  = result;
      end else begin
         data_in.right = result;
      end
   end

   // Take a new block when empty or when the neighbour drains this one.
   assign in_ready = ~valid_ff | out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[src/tea16_checker.sv]
// Port-level assertions for the TEA core, bound to the top level.
`default_nettype none

module tea16_checker import tea16_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // Nothing leaves in the cycle after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // With the output empty the whole row can move, so input must be open.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked while output empty");

   // A stalled result stays offered.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled result keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response changed while stalled");

endmodule

bind tea_block_cipher_16_round_core tea16_checker u_tea16_checker (.*);

`default_nettype wire

[dv/tea_block_cipher_16_round_core_test.sv]
// Self-checking testbench for the pipelined TEA encipher/decipher core.
`timescale 1ns / 100ps

module tea_block_cipher_16_round_core_test;
   import tea16_pkg::*;

   // Hold the receiver off long enough for every cell of the row to fill.
   localparam int unsigned LONG_STALL_CYCLES = 200;
   localparam int unsigned PHASES            = 6;
   localparam int unsigned ITEMS_PER_PHASE   = 260;
   localparam int unsigned REPORT_LIMIT      = 10;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_data    = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_wr_en   = 1'b0;
   logic [1:0]      csr_index   = CSR_KEY_WORD_0;
   logic [31:0]     csr_wr_data = '0;

   // Blocks waiting to be offered, and cipher outputs still owed by the core.
   req_payload_type pending_blocks[$];
   rsp_payload_type expected_blocks[$];

   // Key as the core should hold it; updated only while the core is idle.
   key_type         key_shadow = '0;

   int unsigned     sender_idle_pct   = 0;
   int unsigned     receiver_idle_pct = 0;
   int unsigned     stall_requests    = 0;
   int unsigned     stalls_served     = 0;
   int unsigned     fail_count        = 0;

   tea_block_cipher_16_round_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // One half of a TEA round: shifted copies of x mixed with the key pair
   // and the running sum, all modulo 2^32.
   function automatic logic [31:0] half_round_term(input logic [31:0] x,
                                                   input logic [31:0] sum,
                                                   input logic [31:0] key_hi,
                                                   input logic [31:0] key_lo);
      logic [31:0] shl;
      logic [31:0] shr;
      shl = {x[27:0], 4'b0000};
      shr = {5'b00000, x[31:5]};
      return (shl + key_hi) ^ (x + sum) ^ (shr + key_lo);
   endfunction

   // Predict the core's output for one block under the given key.
   function automatic rsp_payload_type tea_cipher(input req_payload_type blk,
                                                  input key_type key);
      logic [31:0]     left;
      logic [31:0]     right;
      logic [31:0]     sum;
      rsp_payload_type res;
      left  = blk.block_left;
      right = blk.block_right;
      sum   = '0;
      if (blk.req_type == OP_ENCRYPT) begin
         repeat (ROUNDS) begin
            sum   = sum + TEA_DELTA;
            left  = left + half_round_term(right, sum, key.word_0, key.word_1);
            right = right + half_round_term(left, sum, key.word_2, key.word_3);
         end
      end else begin
         // Start from the sum the encipher pass ends on and walk it back.
         repeat (ROUNDS) sum = sum + TEA_DELTA;
         repeat (ROUNDS) begin
            right = right - half_round_term(left, sum, key.word_2, key.word_3);
            left  = left - half_round_term(right, sum, key.word_0, key.word_1);
            sum   = sum - TEA_DELTA;
         end
      end
      res.out_left  = left;
      res.out_right = right;
      return res;
   endfunction

   function automatic logic [31:0] random_word();
      logic [31:0] bit_mask;
      bit_mask = 32'h1 << $urandom_range(31);
      case ($urandom_range(7))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return bit_mask;
         3:       return ~bit_mask;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic pipeline_idle();
      return pending_blocks.size() == 0 && !req_valid && expected_blocks.size() == 0;
   endfunction

   task automatic queue_block(input logic op, input logic [31:0] left,
                              input logic [31:0] right);
      req_payload_type blk;
      blk.req_type    = op;
      blk.block_left  = left;
      blk.block_right = right;
      pending_blocks.insert(pending_blocks.size(), blk);
   endtask

   // Queue a random block, and now and then the block that undoes it, so that
   // encipher/decipher pairs under the live key run through the core.
   task automatic queue_random_block(output int unsigned added);
      req_payload_type blk;
      rsp_payload_type undone;
      blk.req_type    = 1'($urandom_range(1));
      blk.block_left  = random_word();
      blk.block_right = random_word();
      pending_blocks.insert(pending_blocks.size(), blk);
      added = 1;
      if ($urandom_range(3) == 0) begin
         undone = tea_cipher(blk, key_shadow);
         queue_block(blk.req_type == OP_ENCRYPT ? OP_DECRYPT : OP_ENCRYPT,
                     undone.out_left, undone.out_right);
         added = 2;
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
   endtask

   // Load all four key words; call only while the core is idle.
   task automatic load_key(input key_type key);
      write_csr(CSR_KEY_WORD_0, key.word_0);
      write_csr(CSR_KEY_WORD_1, key.word_1);
      write_csr(CSR_KEY_WORD_2, key.word_2);
      write_csr(CSR_KEY_WORD_3, key.word_3);
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      key_shadow = key;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("mismatch on %s: expected %08h, got %08h", what, want, got);
   endtask

   // Driver: on each edge, record an accepted transaction with its predicted
   // output, then decide what the request channel offers next. Valid is only
   // changed once the current transaction has gone, so it never drops early.
   always @(posedge clock) begin : request_driver
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_blocks.insert(expected_blocks.size(),
                                   tea_cipher(req_data, key_shadow));
         if (!req_valid || req_ready) begin
            offer = pending_blocks.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct;
            if (offer) begin
               req_data  <= pending_blocks.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check every accepted result against the oldest prediction and
   // drive rsp_ready, including the long hold-off used to fill the core.
   always @(posedge clock) begin : result_monitor
      int unsigned     stall_left;
      rsp_payload_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("result %08h_%08h arrived with none outstanding",
                           rsp_data.out_left, rsp_data.out_right);
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_data.out_left !== want.out_left)
                  report_mismatch("out_left", want.out_left, rsp_data.out_left);
               if (rsp_data.out_right !== want.out_right)
                  report_mismatch("out_right", want.out_right, rsp_data.out_right);
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (stalls_served != stall_requests) begin
            stalls_served++;
            stall_left = LONG_STALL_CYCLES;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= $urandom_range(99) >= receiver_idle_pct;
         end
      end
   end

   // Stimulus: reset, directed corners under an all-zero key, then random
   // phases over several keys and idle mixes.
   initial begin : stimulus
      key_type         key;
      rsp_payload_type fwd;
      int unsigned     pushed;
      int unsigned     added;
      int unsigned     chunk;
      int unsigned     chunk_no;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Write every word even though reset already cleared the key.
      load_key('0);

      @(negedge clock);
      queue_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
      queue_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
      queue_block(OP_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
      queue_block(OP_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
      queue_block(OP_ENCRYPT, 32'h0000_0000, 32'hffff_ffff);
      queue_block(OP_ENCRYPT, 32'hffff_ffff, 32'h0000_0000);
      queue_block(OP_DECRYPT, 32'h0000_0000, 32'hffff_ffff);
      queue_block(OP_DECRYPT, 32'hffff_ffff, 32'h0000_0000);
      queue_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
      queue_block(OP_DECRYPT, 32'h0000_0001, 32'h8000_0000);
      queue_block(OP_ENCRYPT, 32'h5555_5555, 32'haaaa_aaaa);
      queue_block(OP_DECRYPT, 32'haaaa_aaaa, 32'h5555_5555);
      queue_block(OP_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
      // Round trips: deciphering a ciphertext, or enciphering a decipher output, must give the original block back.
      fwd = tea_cipher({OP_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef}, key_shadow);
      queue_block(OP_DECRYPT, fwd.out_left, fwd.out_right);
      fwd = tea_cipher({OP_DECRYPT, 32'h0000_0000, 32'h0000_0000}, key_shadow);
      queue_block(OP_ENCRYPT, fwd.out_left, fwd.out_right);

      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         while (!pipeline_idle()) @(negedge clock);

         // Sender light and receiver heavy, then the reverse, then no idling.
         case (phase / 2)
            0: begin
               sender_idle_pct   = 17;
               receiver_idle_pct = 73;
            end
            1: begin
               sender_idle_pct   = 73;
               receiver_idle_pct = 17;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase

         case (phase)
            0:       key = {4{32'hffff_ffff}};
            2:       key = {32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa};
            5:       key = {32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000};
            default: key = {$urandom(), $urandom(), $urandom(), $urandom()};
         endcase
         load_key(key);

         pushed   = 0;
         chunk_no = 0;
         while (pushed < ITEMS_PER_PHASE) begin
            @(negedge clock);
            chunk = $urandom_range(20, 60);
            for (int unsigned i = 0; i < chunk; i += added) begin
               queue_random_block(added);
               pushed += added;
            end
            // Stall the receiver once per phase while the sender keeps going.
            if (chunk_no == 1) stall_requests++;
            while (pending_blocks.size() != 0) @(negedge clock);
            // Every third chunk, let the core drain completely before going on.
            if (chunk_no % 3 == 2)
               while (!pipeline_idle()) @(negedge clock);
            chunk_no++;
         end
      end

      while (!pipeline_idle()) @(negedge clock);
      // Allow for a stray result still travelling down the row.
      repeat (2 * CELLS + 10) @(posedge clock);
      if (expected_blocks.size() != 0) fail_count++;
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

[tea_block_cipher_16_round_core.f]
src/tea16_pkg.sv
src/tea16_cell.sv
src/tea_block_cipher_16_round_core.sv
src/tea16_checker.sv
dv/tea_block_cipher_16_round_core_test.sv
